/* hw/rtl/ialu_pkg.sv */
package ialu_pkg;

   // Operation codes carried on req_type.
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;
   localparam logic [2:0] OP_SQRT = 3'd5;
   localparam logic [2:0] OP_POW  = 3'd6;

   // Status codes carried on rsp_status.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_SQRT_NEG = 2'd2;
   localparam logic [1:0] ST_BAD_OP   = 2'd3;

   localparam int DEF_DATA_WIDTH     = 32;
   localparam int DEF_SQRT_FRAC_BITS = 16;

   localparam int FIELD_WIDTH  = 32;
   localparam int RESULT_WIDTH = 33;

endpackage

/* hw/rtl/integer_calculator_alu.sv */
// Channel    Ports                                              Handshake
// request    req_type, req_operand_a, req_operand_b             start & !busy
// response   rsp_result_value, rsp_status                       rsp_valid, one cycle
//
// Add and subtract pass through S_ADDSUB and S_DONE before the registered response strobe.
// Multiply runs shift-and-add, one multiplier bit per step, until the remaining multiplier is zero.
// Divide runs DATA_WIDTH restoring steps plus sign handling.
// Square root runs (DATA_WIDTH+1)/2 + SQRT_FRAC_BITS digit steps.
// Power chains multiplies through the same adder: up to two multiplies per exponent bit.
// Reset is synchronous and returns the sequencer to idle; the receiver cannot stall responses.
module integer_calculator_alu #(
   parameter int DATA_WIDTH     = ialu_pkg::DEF_DATA_WIDTH,
   parameter int SQRT_FRAC_BITS = ialu_pkg::DEF_SQRT_FRAC_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [2:0]                                req_type,
   input  logic signed [ialu_pkg::FIELD_WIDTH-1:0]   req_operand_a,
   input  logic signed [ialu_pkg::FIELD_WIDTH-1:0]   req_operand_b,
   output logic                                      rsp_valid,
   output logic signed [ialu_pkg::RESULT_WIDTH-1:0]  rsp_result_value,
   output logic [1:0]                                rsp_status
);
   import ialu_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int HP  = (W + 1) / 2;             // digit pairs in the integer part
   localparam int P   = HP + SQRT_FRAC_BITS;     // root bits
   localparam int AW  = (W + 1 > P + 3) ? W + 1 : P + 3;
   localparam int SW  = (W > 2 * HP) ? W : 2 * HP;
   localparam int NMX = (W > P) ? W : P;
   localparam int CW  = $clog2(NMX + 1);
   localparam int MW  = (W > RESULT_WIDTH) ? W : RESULT_WIDTH;
   localparam int RX  = (P > RESULT_WIDTH) ? P : RESULT_WIDTH;

   // Sequencer states.
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ADDSUB  = 4'd1;
   localparam logic [3:0] S_MUL     = 4'd2;
   localparam logic [3:0] S_DIV_NA  = 4'd3;
   localparam logic [3:0] S_DIV_NB  = 4'd4;
   localparam logic [3:0] S_DIV     = 4'd5;
   localparam logic [3:0] S_DIV_FIX = 4'd6;
   localparam logic [3:0] S_SQRT    = 4'd7;
   localparam logic [3:0] S_POW     = 4'd8;
   localparam logic [3:0] S_DONE    = 4'd9;

   // Where a finished multiply hands its product.
   localparam logic [1:0] RET_DONE  = 2'd0;
   localparam logic [1:0] RET_POW_R = 2'd1;
   localparam logic [1:0] RET_POW_S = 2'd2;

   logic [3:0]     state_ff, state_in;
   logic [2:0]     op_ff, op_in;
   logic [1:0]     status_ff, status_in;
   logic [1:0]     ret_ff, ret_in;
   logic           neg_ff, neg_in;
   logic [W-1:0]   opa_ff, opa_in;
   logic [W-1:0]   opb_ff, opb_in;
   logic [W-1:0]   x_ff, x_in;
   logic [W-1:0]   y_ff, y_in;
   logic [W-1:0]   res_ff, res_in;
   logic [AW-1:0]  acc_ff, acc_in;
   logic [SW-1:0]  q_ff, q_in;
   logic [P-1:0]   root_ff, root_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [RESULT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;

   // The one shared adder/subtractor; a carry out on subtract means no borrow.
   logic [AW-1:0]  add_x, add_y;
   logic           add_sub;
   logic [AW:0]    sum_full;
   logic [AW-1:0]  sum;
   logic           carry;

   logic [W-1:0]   a_word, b_word;
   logic [AW-1:0]  rem_sh;
   logic [1:0]     pair;
   logic signed [MW-1:0] res_ext;
   logic [RX-1:0]  root_ext;

   assign a_word = W'($signed(req_operand_a));
   assign b_word = W'($signed(req_operand_b));
   assign pair   = q_ff[2*HP-1 -: 2];

   assign sum_full = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                     + (AW+1)'(add_sub);
   assign sum   = sum_full[AW-1:0];
   assign carry = sum_full[AW];

   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      rem_sh  = '0;
      unique case (state_ff)
         S_ADDSUB: begin
            add_x   = AW'(opa_ff);
            add_y   = AW'(opb_ff);
            add_sub = (op_ff == OP_SUB);
         end
         S_MUL: begin
            add_x = AW'(acc_ff[W-1:0]);
            add_y = AW'(x_ff);
         end
         S_DIV_NA: begin
            add_y   = AW'(opa_ff);
            add_sub = 1'b1;
         end
         S_DIV_NB: begin
            add_y   = AW'(opb_ff);
            add_sub = 1'b1;
         end
         S_DIV: begin
            rem_sh  = AW'({acc_ff[W-1:0], q_ff[W-1]});
            add_x   = rem_sh;
            add_y   = AW'(opb_ff);
            add_sub = 1'b1;
         end
         S_DIV_FIX: begin
            add_y   = AW'(q_ff[W-1:0]);
            add_sub = 1'b1;
         end
         S_SQRT: begin
            rem_sh  = {acc_ff[AW-3:0], pair};
            add_x   = rem_sh;
            add_y   = AW'({root_ff, 2'b01});
            add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      ret_in        = ret_ff;
      neg_in        = neg_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      res_in        = res_ff;
      acc_in        = acc_ff;
      q_in          = q_ff;
      root_in       = root_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      res_ext       = MW'($signed(res_ff));
      root_ext      = RX'(root_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_type;
               opa_in    = a_word;
               opb_in    = b_word;
               status_in = ST_OK;
               priority case (req_type)
                  OP_ADD, OP_SUB: begin
                     state_in = S_ADDSUB;
                  end
                  OP_MUL: begin
                     x_in     = a_word;
                     y_in     = b_word;
                     acc_in   = '0;
                     ret_in   = RET_DONE;
                     state_in = S_MUL;
                  end
                  OP_DIV: begin
                     if (b_word == '0) begin
                        status_in = ST_DIV_ZERO;
                        state_in  = S_DONE;
                     end else begin
                        neg_in   = a_word[W-1] ^ b_word[W-1];
                        state_in = S_DIV_NA;
                     end
                  end
                  OP_SQRT: begin
                     if (a_word[W-1]) begin
                        status_in = ST_SQRT_NEG;
                        state_in  = S_DONE;
                     end else begin
                        q_in     = SW'(a_word);
                        acc_in   = '0;
                        root_in  = '0;
                        cnt_in   = CW'(P);
                        state_in = S_SQRT;
                     end
                  end
                  OP_POW: begin
                     // An exponent of one or less returns the base.
                     if (a_word[W-1] || (a_word[W-1:1] == '0)) begin
                        res_in   = b_word;
                        state_in = S_DONE;
                     end else begin
                        res_in   = W'(1);
                        state_in = S_POW;
                     end
                  end
                  default: begin
                     status_in = ST_BAD_OP;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         S_ADDSUB: begin
            res_in   = sum[W-1:0];
            state_in = S_DONE;
         end

         S_MUL: begin
            if (y_ff == '0) begin
               unique case (ret_ff)
                  RET_POW_R: begin
                     // Product goes to the running result; then square the base.
                     res_in = acc_ff[W-1:0];
                     x_in   = opb_ff;
                     y_in   = opb_ff;
                     acc_in = '0;
                     ret_in = RET_POW_S;
                  end
                  RET_POW_S: begin
                     opb_in   = acc_ff[W-1:0];
                     opa_in   = opa_ff >> 1;
                     state_in = S_POW;
                  end
                  default: begin
                     res_in   = acc_ff[W-1:0];
                     state_in = S_DONE;
                  end
               endcase
            end else begin
               if (y_ff[0]) begin
                  acc_in = AW'(sum[W-1:0]);
               end
               x_in = x_ff << 1;
               y_in = y_ff >> 1;
            end
         end

         S_POW: begin
            acc_in = '0;
            if (opa_ff == '0) begin
               state_in = S_DONE;
            end else if (opa_ff[0]) begin
               x_in     = res_ff;
               y_in     = opb_ff;
               ret_in   = RET_POW_R;
               state_in = S_MUL;
            end else begin
               x_in     = opb_ff;
               y_in     = opb_ff;
               ret_in   = RET_POW_S;
               state_in = S_MUL;
            end
         end

         S_DIV_NA: begin
            if (opa_ff[W-1]) begin
               opa_in = sum[W-1:0];
            end
            state_in = S_DIV_NB;
         end

         S_DIV_NB: begin
            if (opb_ff[W-1]) begin
               opb_in = sum[W-1:0];
            end
            q_in     = SW'(opa_ff);
            acc_in   = '0;
            cnt_in   = CW'(W);
            state_in = S_DIV;
         end

         S_DIV: begin
            acc_in = carry ? sum : rem_sh;
            q_in   = SW'({q_ff[W-2:0], carry});
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_DIV_FIX;
            end
         end

         S_DIV_FIX: begin
            res_in   = neg_ff ? sum[W-1:0] : q_ff[W-1:0];
            state_in = S_DONE;
         end

         S_SQRT: begin
            if (carry) begin
               acc_in  = sum;
               root_in = {root_ff[P-2:0], 1'b1};
            end else begin
               acc_in  = rem_sh;
               root_in = {root_ff[P-2:0], 1'b0};
            end
            q_in   = q_ff << 2;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            if (status_ff != ST_OK) begin
               rsp_value_in = '0;
            end else if (op_ff == OP_SQRT) begin
               rsp_value_in = root_ext[RESULT_WIDTH-1:0];
            end else begin
               rsp_value_in = res_ext[RESULT_WIDTH-1:0];
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      ret_ff        <= ret_in;
      neg_ff        <= neg_in;
      opa_ff        <= opa_in;
      opb_ff        <= opb_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      res_ff        <= res_in;
      acc_ff        <= acc_in;
      q_ff          <= q_in;
      root_ff       <= root_in;
      cnt_ff        <= cnt_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* test/integer_calculator_alu_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the integer calculator ALU.
// Every accepted request gets its expected response worked out by a local
// predictor. The response checker compares each strobed response with the
// oldest outstanding expectation.
module integer_calculator_alu_tb;
   import ialu_pkg::*;

   // One outstanding expectation: the value and status that a request must produce.
   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] value;
      logic [1:0]                     status;
   } alu_answer_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS    = 10;

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [2:0]                     req_type;
   logic signed [FIELD_WIDTH-1:0]  req_operand_a;
   logic signed [FIELD_WIDTH-1:0]  req_operand_b;
   logic                           rsp_valid;
   logic signed [RESULT_WIDTH-1:0] rsp_result_value;
   logic [1:0]                     rsp_status;

   alu_answer_type pending_answers[$];
   int          mismatch_count;
   int          response_count;
   int          idle_cycles;
   int          ops_sent[8];

   integer_calculator_alu i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor of the square root of a with 16 fraction bits, found one result bit per
   // step from the 64-bit radicand a * 2^32.
   function automatic logic [31:0] fixed_sqrt(input logic [31:0] a);
      logic [63:0] radicand;
      logic [65:0] remainder;
      logic [65:0] trial;
      logic [31:0] root;
      radicand  = {a, 32'd0};
      remainder = '0;
      root      = '0;
      for (int k = 31; k >= 0; k--) begin
         remainder = (remainder << 2) | radicand[2*k +: 2];
         trial     = ({34'd0, root} << 2) | 66'd1;
         if (remainder >= trial) begin
            remainder = remainder - trial;
            root      = (root << 1) | 32'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   // Base raised to the exponent modulo 2^32; an exponent of one or less gives the base.
   function automatic logic [31:0] wrapped_power(input logic signed [31:0] exponent,
                                                 input logic [31:0] base);
      logic [31:0] product;
      logic [31:0] square;
      logic [31:0] bits_left;
      if (exponent <= 1) return base;
      product   = 32'd1;
      square    = base;
      bits_left = exponent;
      for (int i = 0; i < 32; i++) begin
         if (bits_left[0]) product = product * square;
         square    = square * square;
         bits_left = bits_left >> 1;
      end
      return product;
   endfunction

   function automatic alu_answer_type compute_answer(input logic [2:0] op,
                                                     input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
      alu_answer_type answer;
      logic [31:0] word;
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      answer.value  = '0;
      answer.status = ST_OK;
      word          = '0;
      case (op)
         OP_ADD: word = a + b;
         OP_SUB: word = a - b;
         OP_MUL: word = a * b;
         OP_DIV: begin
            if (b == 0) begin
               answer.status = ST_DIV_ZERO;
            end else begin
               mag_a = a[31] ? -a : a;
               mag_b = b[31] ? -b : b;
               word  = mag_a / mag_b;
               // Truncation toward zero: negate the magnitude quotient on a sign mismatch.
               if (a[31] != b[31]) word = -word;
            end
         end
         OP_POW: word = wrapped_power(a, b);
         default: ;
      endcase
      if (op == OP_ADD || op == OP_SUB || op == OP_MUL || op == OP_DIV || op == OP_POW) begin
         answer.value = {word[31], word};
      end else if (op == OP_SQRT) begin
         // The root is unsigned, so it is zero-extended rather than sign-extended.
         if (a[31]) answer.status = ST_SQRT_NEG;
         else       answer.value  = {1'b0, fixed_sqrt(a)};
      end else begin
         answer.status = ST_BAD_OP;
      end
      return answer;
   endfunction

   // Sends one request after a random gap and returns at the edge where it is taken.
   // The start line is left high so that a back-to-back request never toggles it.
   task automatic send_request(input logic [2:0] op, input logic signed [31:0] a,
                               input logic signed [31:0] b);
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_type      <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (busy);
      pending_answers.push_back(compute_answer(op, a, b));
      ops_sent[op]++;
   endtask

   // Holds the request line low until every outstanding response has arrived.
   task automatic drain_responses();
      start <= 1'b0;
      while (pending_answers.size() > 0) @(posedge clock);
   endtask

   // An operand that is fully random half the time, otherwise a corner value or a small one.
   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom_range(0, 2) - 1;
         3, 4: return $signed($urandom_range(0, 200)) - 100;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_add_sub_mul();
      send_request(OP_ADD, 32'sh7fffffff, 32'sd1);
      send_request(OP_ADD, 32'sh80000000, -32'sd1);
      send_request(OP_ADD, 32'sd0, 32'sd0);
      send_request(OP_SUB, 32'sh80000000, 32'sd1);
      send_request(OP_SUB, 32'sd0, 32'sh80000000);
      send_request(OP_MUL, 32'sh7fffffff, 32'sh7fffffff);
      send_request(OP_MUL, 32'sh80000000, -32'sd1);
      send_request(OP_MUL, -32'sd1, -32'sd1);
   endtask

   task automatic test_divide();
      send_request(OP_DIV, 32'sh80000000, -32'sd1);
      send_request(OP_DIV, 32'sd7, 32'sd0);
      send_request(OP_DIV, -32'sd7, 32'sd2);
      send_request(OP_DIV, 32'sd7, -32'sd2);
      send_request(OP_DIV, 32'sh7fffffff, 32'sh80000000);
   endtask

   task automatic test_square_root();
      send_request(OP_SQRT, 32'sd0, 32'sd0);
      send_request(OP_SQRT, 32'sd2, 32'sd0);
      send_request(OP_SQRT, 32'sh7fffffff, 32'sd0);
      send_request(OP_SQRT, -32'sd1, 32'sd0);
      send_request(OP_SQRT, 32'sh80000000, 32'sd0);
   endtask

   task automatic test_power();
      send_request(OP_POW, 32'sd0, 32'sd5);
      send_request(OP_POW, 32'sd1, -32'sd3);
      send_request(OP_POW, 32'sh80000000, 32'sd9);
      send_request(OP_POW, 32'sd31, 32'sd2);
      send_request(OP_POW, 32'sh7fffffff, 32'sd3);
   endtask

   task automatic test_unknown_ops();
      send_request(3'd0, 32'sh7fffffff, 32'sh80000000);
      send_request(3'd7, -32'sd1, 32'sd0);
   endtask

   // Mixed traffic. Power exponents are mostly small, since each exponent bit can cost
   // two multiplies.
   task automatic test_random_mix(input int count);
      logic [2:0]         op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(0, 19) == 0) ? (($urandom_range(0, 1) == 0) ? 3'd0 : 3'd7)
                                           : 3'($urandom_range(1, 6));
         a  = pick_operand();
         b  = pick_operand();
         if (op == OP_POW && $urandom_range(0, 29) != 0)
            a = $signed($urandom_range(0, 45)) - 5;
         send_request(op, a, b);
         // Now and then let the block run completely dry before going on.
         if (n % 350 == 175) drain_responses();
      end
   endtask

   // Response checker: each strobe is matched against the oldest expectation.
   always @(posedge clock) begin
      alu_answer_type wanted;
      if (!reset && rsp_valid) begin
         response_count++;
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("Response with no outstanding request: value %h status %0d",
                        rsp_result_value, rsp_status);
         end else begin
            wanted = pending_answers.pop_front();
            if (rsp_result_value !== wanted.value || rsp_status !== wanted.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("Mismatch: expected value %h status %0d, got value %h status %0d",
                           wanted.value, wanted.status, rsp_result_value, rsp_status);
            end
         end
      end
   end

   // Watchdog: the run is abandoned when nothing is accepted and no response arrives for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d responses outstanding",
                     pending_answers.size());
            $display("integer_calculator_alu regression: fail");
            $finish;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_type       = '0;
      req_operand_a  = '0;
      req_operand_b  = '0;
      mismatch_count = 0;
      response_count = 0;
      idle_cycles    = 0;
      foreach (ops_sent[i]) ops_sent[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_add_sub_mul();
      test_divide();
      test_square_root();
      test_power();
      test_unknown_ops();
      test_random_mix(1400);

      drain_responses();
      // Keep the clock running to catch any stray response.
      repeat (100) @(posedge clock);

      $display("Checked %0d responses: add %0d, sub %0d, mul %0d, div %0d, sqrt %0d, pow %0d,",
               response_count, ops_sent[OP_ADD], ops_sent[OP_SUB], ops_sent[OP_MUL],
               ops_sent[OP_DIV], ops_sent[OP_SQRT], ops_sent[OP_POW]);
      $display("unknown codes %0d, mismatches %0d.", ops_sent[0] + ops_sent[7],
               mismatch_count);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("integer_calculator_alu regression: pass");
      end else begin
         $display("integer_calculator_alu regression: fail");
      end
      $finish;
   end

endmodule
